FILE: hdl/quaternion_alu_top_macros.svh
// Assertion macros shared by the quaternion ALU top level.
`ifndef QUATERNION_ALU_TOP_MACROS_SVH
`define QUATERNION_ALU_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QALU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QALU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/qalu_pkg.sv
// Types, constants and helper functions of the quaternion ALU.
package qalu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 66;
   localparam int SQ_W      = 65;
   localparam int NORM_W    = SQ_W - FRAC_BITS;
   localparam int MAG_W     = 32 + FRAC_BITS;
   localparam int DIVD_W    = ((MAG_W > NORM_W) ? MAG_W : NORM_W) + 1;
   localparam int QUO_W     = 33;
   localparam int PIPE_D    = QUO_W + 6;

   localparam logic signed [SUM_W-1:0] HALF_S  = SUM_W'(2 ** (FRAC_BITS - 1));
   localparam logic [SQ_W-1:0]         HALF_U  = SQ_W'(2 ** (FRAC_BITS - 1));
   localparam logic [31:0]             ONE_FIX = 32'(2 ** FRAC_BITS);
   localparam logic [31:0]             MAX_Q   = 32'h7fff_ffff;
   localparam logic [31:0]             MIN_Q   = 32'h8000_0000;
   localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] NEG_LIM = SUM_W'(-64'sd2147483648);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_INV = 3'd4,
      OP_ROT = 3'd5
   } op_type;

   // Index 0 is the scalar part, then i, j, k.
   typedef logic [3:0][31:0] quat_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] a_w;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_w;
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic               zero_norm;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      op_type   op;
      logic     kill;
      quat_type a;
      quat_type b;
      quat_type x;
   } cmd_type;

   typedef struct packed {
      logic    vld;
      cmd_type cmd;
   } head_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] val;
   } satw_type;

   typedef struct packed {
      op_type     op;
      logic       kill;
      quat_type   a;
      quat_type   early;
      logic       early_sat;
      logic       zero;
      logic [3:0] neg;
      logic [3:0] ovf;
   } side_type;

   typedef struct packed {
      op_type   op;
      logic     kill;
      quat_type a;
      quat_type early;
      logic     early_sat;
      logic     zero;
      quat_type inv;
      logic     inv_sat;
   } fin_type;

   function automatic satw_type sat32(input logic signed [SUM_W-1:0] v);
      satw_type res;
      if (v > POS_LIM) begin
         res.sat = 1'b1;
         res.val = MAX_Q;
      end else if (v < NEG_LIM) begin
         res.sat = 1'b1;
         res.val = MIN_Q;
      end else begin
         res.sat = 1'b0;
         res.val = v[31:0];
      end
      return res;
   endfunction

endpackage

FILE: hdl/quaternion_alu_top.sv
// Top level of the quaternion ALU: front queue, arithmetic pipeline and output register.
//
// The request side looks like the write end of a queue: a request (operation code plus
// quaternions A and B) is taken at a rising edge with push high and full low. The result
// side looks like the read end of a queue: while empty is low the oldest result sits on
// rsp_data, and it is taken at a rising edge with pop high.
// One request per cycle is accepted and one result per cycle is delivered when the
// receiver keeps popping. Every operation takes the same path to its result: three
// setup stages, the 33-stage restoring divider that forms the inverse, one stage to
// finish the inverse and two stages of the final product.
// Every request gives exactly one result, in request order.
// When the receiver stalls with a result waiting, the whole pipeline holds; the two-entry
// queue at the front keeps taking requests until it fills, then full goes high.
// Reset empties both queues and clears every valid flag; no result is lost or repeated
// across a stall.
`include "quaternion_alu_top_macros.svh"

module quaternion_alu_top import qalu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   head_type head;
   logic     adv;
   logic     back_vld;
   rsp_type  back_data;
   logic     out_vld_ff;
   rsp_type  rsp_ff;

   // The pipeline moves whenever the output register is free or being read.
   assign adv = !out_vld_ff || pop;

   qalu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .pop_head (adv),
      .head     (head)
   );

   qalu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .head     (head),
      .out_vld  (back_vld),
      .out_data (back_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= back_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && back_vld) begin
         rsp_ff <= back_data;
      end
   end

   assign empty    = !out_vld_ff;
   assign rsp_data = rsp_ff;

   // A full front queue always has a request at its head.
   `QALU_ASSERT_NOW(a_full_has_head, full, head.vld, "front queue full without a head request")
   // A finished result behind a stalled output register must stay in the pipeline.
   `QALU_ASSERT_NEXT(a_stall_holds, back_vld && out_vld_ff && !pop, back_vld, "result lost in stall")
   // An identity inverse never leads to a clamped component.
   `QALU_ASSERT_NOW(a_zero_no_sat, !empty && rsp_data.zero_norm, !rsp_data.saturated, "zero norm with saturation")

endmodule

FILE: hdl/qalu_front.sv
// Front end: request decode and a two-entry queue ahead of the datapath.
module qalu_front import qalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   input  logic     pop_head,
   output head_type head
);

   cmd_type    slot_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   // Unknown operation codes are marked so the back end drives all zeros.
   always_comb begin
      cmd_in.kill = (req_data.operation > OP_ROT);
      cmd_in.op   = cmd_in.kill ? OP_ADD : op_type'(req_data.operation);
      cmd_in.a    = {req_data.a_z, req_data.a_y, req_data.a_x, req_data.a_w};
      cmd_in.b    = {req_data.b_z, req_data.b_y, req_data.b_x,
                     (cmd_in.op == OP_ROT) ? 32'd0 : req_data.b_w};
      cmd_in.x    = (cmd_in.op == OP_DIV) ? cmd_in.b : cmd_in.a;
   end

   assign full     = (cnt_ff == 2'd2);
   assign head.vld = (cnt_ff != 2'd0);
   assign head.cmd = slot_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop_head && head.vld;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      unique case ({push_ok, pop_ok})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

FILE: hdl/qalu_ham.sv
// Two-stage Hamilton product with rounding and saturation.
module qalu_ham import qalu_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  quat_type a,
   input  quat_type b,
   output quat_type r,
   output logic     sat_w,
   output logic     sat_v
);

   logic signed [63:0]      prod_ff [4][4];
   logic signed [63:0]      prod_in [4][4];
   logic signed [SUM_W-1:0] sum_c [4];
   logic signed [SUM_W-1:0] rnd_c [4];
   satw_type                sw [4];
   quat_type                r_ff, r_in;
   logic                    sat_w_ff, sat_v_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = 64'($signed(a[i])) * 64'($signed(b[j]));
         end
      end
   end

   // Exact sums of the four partial products for each component.
   always_comb begin
      sum_c[0] = SUM_W'(prod_ff[0][0]) - SUM_W'(prod_ff[1][1])
               - SUM_W'(prod_ff[2][2]) - SUM_W'(prod_ff[3][3]);
      sum_c[1] = SUM_W'(prod_ff[0][1]) + SUM_W'(prod_ff[1][0])
               + SUM_W'(prod_ff[2][3]) - SUM_W'(prod_ff[3][2]);
      sum_c[2] = SUM_W'(prod_ff[0][2]) - SUM_W'(prod_ff[1][3])
               + SUM_W'(prod_ff[2][0]) + SUM_W'(prod_ff[3][1]);
      sum_c[3] = SUM_W'(prod_ff[0][3]) + SUM_W'(prod_ff[1][2])
               - SUM_W'(prod_ff[2][1]) + SUM_W'(prod_ff[3][0]);
      for (int i = 0; i < 4; i++) begin
         rnd_c[i] = (sum_c[i] + HALF_S) >>> FRAC_BITS;
         sw[i]    = sat32(rnd_c[i]);
         r_in[i]  = sw[i].val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         r_ff     <= r_in;
         sat_w_ff <= sw[0].sat;
         sat_v_ff <= sw[1].sat | sw[2].sat | sw[3].sat;
      end
   end

   assign r     = r_ff;
   assign sat_w = sat_w_ff;
   assign sat_v = sat_v_ff;

endmodule

FILE: hdl/qalu_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, one bit per stage.
module qalu_div import qalu_pkg::*; (
   input  logic                         clock,
   input  logic                         en,
   input  logic [3:0][DIVD_W-1:0]       dvd,
   input  logic [NORM_W-1:0]            dvs,
   output logic [3:0][QUO_W-1:0]        quo
);

   logic [NORM_W-1:0] rem_ff [QUO_W][4];
   logic [QUO_W-1:0]  quo_ff [QUO_W][4];
   logic [DIVD_W-1:0] dvd_ff [QUO_W][4];
   logic [NORM_W-1:0] dvs_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [NORM_W-1:0] dvs_prev;

      if (k == 0) begin : g_first
         assign dvs_prev = dvs;
      end else begin : g_next
         assign dvs_prev = dvs_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvs_ff[k] <= dvs_prev;
         end
      end

      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic [NORM_W-1:0] rem_prev, rem_in;
         logic [QUO_W-1:0]  quo_prev;
         logic [DIVD_W-1:0] dvd_prev;
         logic [NORM_W:0]   trial, diff;
         logic              fits;

         if (k == 0) begin : g_first
            assign rem_prev = NORM_W'(dvd[l] >> QUO_W);
            assign quo_prev = '0;
            assign dvd_prev = dvd[l];
         end else begin : g_next
            assign rem_prev = rem_ff[k-1][l];
            assign quo_prev = quo_ff[k-1][l];
            assign dvd_prev = dvd_ff[k-1][l];
         end

         assign trial  = {rem_prev, dvd_prev[QUO_W-1-k]};
         assign diff   = trial - {1'b0, dvs_prev};
         assign fits   = (trial >= {1'b0, dvs_prev});
         assign rem_in = fits ? diff[NORM_W-1:0] : trial[NORM_W-1:0];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l] <= rem_in;
               quo_ff[k][l] <= {quo_prev[QUO_W-2:0], fits};
               dvd_ff[k][l] <= dvd_prev;
            end
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_out
      assign quo[l] = quo_ff[QUO_W-1][l];
   end

endmodule

FILE: hdl/qalu_back.sv
// Back end: arithmetic pipeline for add, subtract, product, inverse, divide and rotate.
module qalu_back import qalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  head_type head,
   output logic     out_vld,
   output rsp_type  out_data
);

   logic [PIPE_D-1:0] vld_ff;

   // Stage 1
   op_type                  s1_op_ff;
   logic                    s1_kill_ff, s1_as_sat_ff, as_sat_in;
   quat_type                s1_a_ff, s1_x_ff, s1_as_ff, as_in;
   logic [3:0][63:0]        s1_sq_ff, sq_in;
   logic signed [SUM_W-1:0] as_sum [4];
   satw_type                as_sw [4];

   // Stage 2
   op_type            s2_op_ff;
   logic              s2_kill_ff, s2_as_sat_ff;
   quat_type          s2_a_ff, s2_x_ff, s2_as_ff;
   logic [NORM_W-1:0] s2_nf_ff, nf_in;
   logic [SQ_W-1:0]   sq_sum;
   quat_type          h1_r;
   logic              h1_sat_w, h1_sat_v;

   // Stage 3
   side_type               s3_side_ff, side_in;
   logic [3:0][DIVD_W-1:0] s3_dvd_ff, dvd_in;
   logic [NORM_W-1:0]      s3_nf_ff;
   logic [3:0][31:0]       mag;
   logic                   use_h1;

   // Divider and the side information that travels beside it
   logic [3:0][QUO_W-1:0] quo;
   side_type              side_ff [QUO_W];
   side_type              sd;

   // Inverse finish and the second product
   fin_type                 s37_ff, s38_ff, s39_ff, fin_in;
   logic signed [SUM_W-1:0] qv [4];
   satw_type                qsw [4];
   quat_type                inv_v, h2_left, h2_r, res;
   logic [3:0]              inv_sat_v;
   logic                    h2_sat_w, h2_sat_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_D-2:0], head.vld};
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (head.cmd.op == OP_SUB) begin
            as_sum[i] = SUM_W'($signed(head.cmd.a[i])) - SUM_W'($signed(head.cmd.b[i]));
         end else begin
            as_sum[i] = SUM_W'($signed(head.cmd.a[i])) + SUM_W'($signed(head.cmd.b[i]));
         end
         as_sw[i] = sat32(as_sum[i]);
         as_in[i] = as_sw[i].val;
         sq_in[i] = 64'($signed(head.cmd.x[i])) * 64'($signed(head.cmd.x[i]));
      end
      as_sat_in = as_sw[0].sat | as_sw[1].sat | as_sw[2].sat | as_sw[3].sat;
   end

   qalu_ham u_ham1 (
      .clock (clock),
      .en    (en),
      .a     (head.cmd.a),
      .b     (head.cmd.b),
      .r     (h1_r),
      .sat_w (h1_sat_w),
      .sat_v (h1_sat_v)
   );

   // Squared norm rounded half up to the fixed-point grid.
   always_comb begin
      sq_sum = SQ_W'(s1_sq_ff[0]) + SQ_W'(s1_sq_ff[1])
             + SQ_W'(s1_sq_ff[2]) + SQ_W'(s1_sq_ff[3]);
      nf_in  = NORM_W'((sq_sum + HALF_U) >> FRAC_BITS);
   end

   // Dividend is |x| scaled up plus half the divisor, so the quotient rounds
   // to nearest with ties away from zero once the sign is put back.
   always_comb begin
      use_h1            = (s2_op_ff == OP_MUL) || (s2_op_ff == OP_ROT);
      side_in.op        = s2_op_ff;
      side_in.kill      = s2_kill_ff;
      side_in.a         = s2_a_ff;
      side_in.early     = use_h1 ? h1_r : s2_as_ff;
      side_in.early_sat = use_h1 ? (h1_sat_w | h1_sat_v) : s2_as_sat_ff;
      side_in.zero      = (s2_nf_ff == '0);
      for (int i = 0; i < 4; i++) begin
         mag[i]         = s2_x_ff[i][31] ? (~s2_x_ff[i] + 32'd1) : s2_x_ff[i];
         dvd_in[i]      = (DIVD_W'(mag[i]) << FRAC_BITS) + DIVD_W'(s2_nf_ff >> 1);
         side_in.neg[i] = s2_x_ff[i][31] ^ (i != 0);
         side_in.ovf[i] = ((dvd_in[i] >> QUO_W) >= DIVD_W'(s2_nf_ff));
      end
   end

   qalu_div u_div (
      .clock (clock),
      .en    (en),
      .dvd   (s3_dvd_ff),
      .dvs   (s3_nf_ff),
      .quo   (quo)
   );

   assign sd = side_ff[QUO_W-1];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qv[i]  = sd.neg[i] ? -SUM_W'(quo[i]) : SUM_W'(quo[i]);
         qsw[i] = sat32(qv[i]);
         if (sd.ovf[i]) begin
            inv_sat_v[i] = 1'b1;
            inv_v[i]     = sd.neg[i] ? MIN_Q : MAX_Q;
         end else begin
            inv_sat_v[i] = qsw[i].sat;
            inv_v[i]     = qsw[i].val;
         end
      end
      fin_in.op        = sd.op;
      fin_in.kill      = sd.kill;
      fin_in.a         = sd.a;
      fin_in.early     = sd.early;
      fin_in.early_sat = sd.early_sat;
      fin_in.zero      = sd.zero;
      fin_in.inv       = sd.zero ? {32'd0, 32'd0, 32'd0, ONE_FIX} : inv_v;
      fin_in.inv_sat   = !sd.zero && (inv_sat_v != 4'd0);
   end

   assign h2_left = (s37_ff.op == OP_DIV) ? s37_ff.a : s37_ff.early;

   qalu_ham u_ham2 (
      .clock (clock),
      .en    (en),
      .a     (h2_left),
      .b     (s37_ff.inv),
      .r     (h2_r),
      .sat_w (h2_sat_w),
      .sat_v (h2_sat_v)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff     <= head.cmd.op;
         s1_kill_ff   <= head.cmd.kill;
         s1_a_ff      <= head.cmd.a;
         s1_x_ff      <= head.cmd.x;
         s1_as_ff     <= as_in;
         s1_as_sat_ff <= as_sat_in;
         s1_sq_ff     <= sq_in;
         s2_op_ff     <= s1_op_ff;
         s2_kill_ff   <= s1_kill_ff;
         s2_a_ff      <= s1_a_ff;
         s2_x_ff      <= s1_x_ff;
         s2_as_ff     <= s1_as_ff;
         s2_as_sat_ff <= s1_as_sat_ff;
         s2_nf_ff     <= nf_in;
         s3_side_ff   <= side_in;
         s3_dvd_ff    <= dvd_in;
         s3_nf_ff     <= s2_nf_ff;
         side_ff[0]   <= s3_side_ff;
         for (int k = 1; k < QUO_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         s37_ff <= fin_in;
         s38_ff <= s37_ff;
         s39_ff <= s38_ff;
      end
   end

   always_comb begin
      res                = '0;
      out_data.zero_norm = 1'b0;
      out_data.saturated = 1'b0;
      case (s39_ff.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            res                = s39_ff.early;
            out_data.saturated = s39_ff.early_sat;
         end
         OP_DIV: begin
            res                = h2_r;
            out_data.zero_norm = s39_ff.zero;
            out_data.saturated = s39_ff.inv_sat | h2_sat_w | h2_sat_v;
         end
         OP_INV: begin
            res                = s39_ff.inv;
            out_data.zero_norm = s39_ff.zero;
            out_data.saturated = s39_ff.inv_sat;
         end
         OP_ROT: begin
            res                = {h2_r[3], h2_r[2], h2_r[1], 32'd0};
            out_data.zero_norm = s39_ff.zero;
            out_data.saturated = s39_ff.early_sat | s39_ff.inv_sat | h2_sat_v;
         end
         default: begin
            res = '0;
         end
      endcase
      if (s39_ff.kill) begin
         res                = '0;
         out_data.zero_norm = 1'b0;
         out_data.saturated = 1'b0;
      end
      out_data.r_w = res[0];
      out_data.r_x = res[1];
      out_data.r_y = res[2];
      out_data.r_z = res[3];
   end

   assign out_vld = vld_ff[PIPE_D-1];

endmodule

FILE: verif/tb_quaternion_alu_top.sv
// Self-checking testbench for the quaternion ALU top level.
`timescale 1ns / 100ps

module tb_quaternion_alu_top;
   import qalu_pkg::*;

   // Operation codes that the package does not name; they must return all zero.
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] QMIN = 32'sh8000_0000;
   localparam logic signed [31:0] QONE = 32'sh0001_0000;

   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_CYCLES = 60;

   typedef logic signed [31:0] comp4_type [4];
   typedef logic signed [79:0] wide_type;

   localparam wide_type ROUND_HALF = wide_type'(1) <<< (FRAC_BITS - 1);

   typedef struct {
      logic [2:0] op;
      comp4_type  a;
      comp4_type  b;
      logic       known;
      rsp_type    result;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   rsp_type      pending_results[$];
   stim_row_type stim_table[$];
   int           mismatch_count = 0;

   // When set, neither side inserts idle cycles.
   bit      quiet = 1'b0;
   // Raised once by the sender; the receiver then holds off pop for a long stretch.
   bit      hold_request = 1'b0;

   quaternion_alu_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor. All intermediate sums are kept exact in 80 bits, which is wide enough
   // for a sum of four full-range 64-bit products, so rounding happens exactly once.
   // ---------------------------------------------------------------------------------

   function automatic logic signed [31:0] clamp_word(input wide_type v, inout logic sat);
      if (v > wide_type'(QMAX)) begin
         sat = 1'b1;
         return QMAX;
      end
      if (v < wide_type'(QMIN)) begin
         sat = 1'b1;
         return QMIN;
      end
      return v[31:0];
   endfunction

   // Round half up to the fixed-point grid, then clamp.
   function automatic logic signed [31:0] round_sum(input wide_type s, inout logic sat);
      return clamp_word((s + ROUND_HALF) >>> FRAC_BITS, sat);
   endfunction

   function automatic wide_type mulw(input logic signed [31:0] x,
                                     input logic signed [31:0] y);
      wide_type xe, ye;
      xe = x;
      ye = y;
      return xe * ye;
   endfunction

   // The two flags are taken by reference so that both may name the same variable.
   function automatic void hamilton_product(input comp4_type a, input comp4_type b,
                                            output comp4_type r,
                                            ref logic sat_w, ref logic sat_v);
      r[0] = round_sum(mulw(a[0], b[0]) - mulw(a[1], b[1]) - mulw(a[2], b[2])
                       - mulw(a[3], b[3]), sat_w);
      r[1] = round_sum(mulw(a[0], b[1]) + mulw(a[1], b[0]) + mulw(a[2], b[3])
                       - mulw(a[3], b[2]), sat_v);
      r[2] = round_sum(mulw(a[0], b[2]) - mulw(a[1], b[3]) + mulw(a[2], b[0])
                       + mulw(a[3], b[1]), sat_v);
      r[3] = round_sum(mulw(a[0], b[3]) + mulw(a[1], b[2]) - mulw(a[2], b[1])
                       + mulw(a[3], b[0]), sat_v);
   endfunction

   // Conjugate over the rounded squared norm; identity when the norm rounds to zero.
   function automatic void invert_quat(input comp4_type a, output comp4_type r,
                                       inout logic zero, inout logic sat);
      wide_type nrm, num, mag, q;
      nrm = 0;
      for (int i = 0; i < 4; i++) nrm += mulw(a[i], a[i]);
      nrm = (nrm + ROUND_HALF) >>> FRAC_BITS;
      if (nrm == 0) begin
         zero = 1'b1;
         r = '{QONE, 32'sd0, 32'sd0, 32'sd0};
         return;
      end
      for (int i = 0; i < 4; i++) begin
         num = a[i];
         num = num <<< FRAC_BITS;
         mag = (num < 0) ? -num : num;
         q = (mag + nrm / 2) / nrm;
         if (num < 0) q = -q;
         if (i != 0) q = -q;
         r[i] = clamp_word(q, sat);
      end
   endfunction

   function automatic rsp_type predict_quat_result(input req_type rq);
      comp4_type a, b, r, t, inv;
      logic      zero, sat, discard;
      rsp_type   res;
      a = '{rq.a_w, rq.a_x, rq.a_y, rq.a_z};
      b = '{rq.b_w, rq.b_x, rq.b_y, rq.b_z};
      r = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
      zero = 1'b0;
      sat = 1'b0;
      discard = 1'b0;
      case (rq.operation)
         OP_ADD: begin
            for (int i = 0; i < 4; i++) r[i] = clamp_word(wide_type'(a[i]) + b[i], sat);
         end
         OP_SUB: begin
            for (int i = 0; i < 4; i++) r[i] = clamp_word(wide_type'(a[i]) - b[i], sat);
         end
         OP_MUL: hamilton_product(a, b, r, sat, sat);
         OP_DIV: begin
            invert_quat(b, inv, zero, sat);
            hamilton_product(a, inv, r, sat, sat);
         end
         OP_INV: invert_quat(a, r, zero, sat);
         OP_ROT: begin
            // The vector is a pure quaternion; the scalar of the last product is dropped.
            b[0] = 32'sd0;
            hamilton_product(a, b, t, sat, sat);
            invert_quat(a, inv, zero, sat);
            hamilton_product(t, inv, r, discard, sat);
            r[0] = 32'sd0;
         end
         default: ;
      endcase
      res.r_w = r[0];
      res.r_x = r[1];
      res.r_y = r[2];
      res.r_z = r[3];
      res.zero_norm = zero;
      res.saturated = sat;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------

   function automatic req_type build_request(input logic [2:0] op, input comp4_type a,
                                             input comp4_type b);
      req_type rq;
      rq.operation = op;
      rq.a_w = a[0];
      rq.a_x = a[1];
      rq.a_y = a[2];
      rq.a_z = a[3];
      rq.b_w = b[0];
      rq.b_x = b[1];
      rq.b_y = b[2];
      rq.b_z = b[3];
      return rq;
   endfunction

   task automatic add_row(input logic [2:0] op, input comp4_type a, input comp4_type b,
                          input logic known, input rsp_type result);
      stim_row_type row;
      row.op = op;
      row.a = a;
      row.b = b;
      row.known = known;
      row.result = result;
      stim_table.push_back(row);
   endtask

   // A random component: moderate Q16.16 values so that products and
   // rotations stay in range, plus tiny values that can drive the norm to zero,
   // extremes, and raw full-width patterns so every bit toggles.
   function automatic logic signed [31:0] random_component();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return $signed(32'($urandom_range(0, 8 * 65536))) - 32'sd262144;
      if (pick == 4) return $signed(32'($urandom_range(0, 400))) - 32'sd200;
      if (pick == 5) begin
         case ($urandom_range(0, 4))
            0: return QMAX;
            1: return QMIN;
            2: return 32'sd0;
            3: return QONE;
            default: return -QONE;
         endcase
      end
      return $signed($urandom());
   endfunction

   // Offers one request and returns once the block has taken it. The expectation is
   // queued at the accepting edge so that it is in place before the result can appear.
   task automatic offer_request(input req_type rq, input logic known, input rsp_type result);
      if (!quiet && $urandom_range(99) < 10) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_results.push_back(known ? result : predict_quat_result(rq));
   endtask

   // ---------------------------------------------------------------------------------
   // Checking.
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: result field %s is %h, expected %h", $realtime, field, got, want);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("(none pending)", got.r_w, 32'h0);
         return;
      end
      want = pending_results.pop_front();
      if (got.r_w !== want.r_w) report_mismatch("r_w", got.r_w, want.r_w);
      if (got.r_x !== want.r_x) report_mismatch("r_x", got.r_x, want.r_x);
      if (got.r_y !== want.r_y) report_mismatch("r_y", got.r_y, want.r_y);
      if (got.r_z !== want.r_z) report_mismatch("r_z", got.r_z, want.r_z);
      if (got.zero_norm !== want.zero_norm)
         report_mismatch("zero_norm", 32'(got.zero_norm), 32'(want.zero_norm));
      if (got.saturated !== want.saturated)
         report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
   endtask

   // Receiver: checks each result taken at this edge, then chooses pop for the next.
   // A long hold-off, counted here, lets the pipeline and front queue fill up.
   initial begin
      int hold_left;
      hold_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) check_result(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (quiet) begin
            pop <= 1'b1;
         end else begin
            pop <= ($urandom_range(99) >= 10);
         end
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(12 * 400000);
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Main sequence: reset, directed table, random requests, drain.
   // ---------------------------------------------------------------------------------
   initial begin
      comp4_type  qa, qb;
      comp4_type  zq, idq, maxq, minq, smallq;
      rsp_type    zr;
      logic [2:0] op;
      int unsigned pick;

      zq = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
      idq = '{QONE, 32'sd0, 32'sd0, 32'sd0};
      maxq = '{QMAX, QMAX, QMAX, QMAX};
      minq = '{QMIN, QMIN, QMIN, QMIN};
      smallq = '{32'sd196608, -32'sd65536, 32'sd131072, 32'sd32768};
      zr = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Results are typed in where they follow directly from the
      // definition; the rest are worked out by the predictor.
      add_row(OP_ADD, zq, zq, 1'b1, zr);
      add_row(OP_ADD, maxq, maxq, 1'b1, '{QMAX, QMAX, QMAX, QMAX, 1'b0, 1'b1});
      add_row(OP_ADD, minq, minq, 1'b1, '{QMIN, QMIN, QMIN, QMIN, 1'b0, 1'b1});
      add_row(OP_SUB, minq, maxq, 1'b1, '{QMIN, QMIN, QMIN, QMIN, 1'b0, 1'b1});
      add_row(OP_SUB, maxq, minq, 1'b1, '{QMAX, QMAX, QMAX, QMAX, 1'b0, 1'b1});
      add_row(OP_SUB, smallq, smallq, 1'b1, zr);
      add_row(OP_MUL, idq, idq, 1'b1, '{QONE, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0});
      add_row(OP_MUL, maxq, maxq, 1'b0, zr);
      add_row(OP_MUL, minq, minq, 1'b0, zr);
      add_row(OP_MUL, maxq, minq, 1'b0, zr);
      // Half an LSB below zero rounds up to zero; half above rounds up to one LSB.
      add_row(OP_MUL, '{32'sd1, 32'sd0, 32'sd0, 32'sd0},
              '{-32'sd32768, 32'sd32768, 32'sd0, 32'sd0}, 1'b0, zr);
      add_row(OP_MUL, smallq, '{32'sd65536, 32'sd98304, -32'sd16384, 32'sd7}, 1'b0, zr);
      // Dividing by a zero quaternion multiplies by the identity instead.
      add_row(OP_DIV, smallq, zq, 1'b1,
              '{smallq[0], smallq[1], smallq[2], smallq[3], 1'b1, 1'b0});
      add_row(OP_DIV, smallq, smallq, 1'b0, zr);
      add_row(OP_DIV, maxq, '{32'sd200, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zr);
      add_row(OP_INV, zq, smallq, 1'b1, '{QONE, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0});
      // A norm too small to survive rounding also counts as zero.
      add_row(OP_INV, '{32'sd100, -32'sd50, 32'sd0, 32'sd3}, zq, 1'b1,
              '{QONE, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0});
      add_row(OP_INV, idq, zq, 1'b1, '{QONE, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0});
      add_row(OP_INV, '{32'sd181, 32'sd181, 32'sd0, 32'sd0}, zq, 1'b0, zr);
      add_row(OP_INV, minq, zq, 1'b0, zr);
      add_row(OP_ROT, idq, '{QMAX, 32'sd65536, 32'sd131072, 32'sd196608}, 1'b0, zr);
      add_row(OP_ROT, zq, smallq, 1'b0, zr);
      add_row(OP_ROT, maxq, maxq, 1'b0, zr);
      add_row(OP_SPARE6, maxq, minq, 1'b1, zr);
      add_row(OP_SPARE7, smallq, maxq, 1'b1, zr);

      foreach (stim_table[i])
         offer_request(build_request(stim_table[i].op, stim_table[i].a, stim_table[i].b),
                       stim_table[i].known, stim_table[i].result);

      // Random part. One stretch runs with no idling on either side, and one long
      // receiver hold-off makes the front queue fill and raise full.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 600 && n < 900);
         if (n == 300) hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 95) op = 3'($urandom_range(0, 5));
         else op = (pick < 97) ? OP_SPARE6 : OP_SPARE7;
         for (int i = 0; i < 4; i++) begin
            qa[i] = random_component();
            qb[i] = random_component();
         end
         offer_request(build_request(op, qa, qb), 1'b0, zr);
      end
      quiet = 1'b0;
      push <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
